>>> hw/rtl/ioole_pkg.sv
package ioole_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // request codes
  typedef enum logic [2:0] {
    REQ_INSERT   = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_FIND     = 3'd2,
    REQ_RETRIEVE = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_type_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // request beat
  typedef struct packed {
    req_type_e   req_type;
    logic [31:0] value;
    logic [4:0]  position;
  } req_t;

  // result beat
  typedef struct packed {
    status_e     status;
    logic        match_found;
    logic [3:0]  match_index;
    logic [31:0] read_data;
    logic [4:0]  entry_count;
    logic        is_empty;
  } res_t;

  // control broadcast to every slot cell
  typedef struct packed {
    logic                  ins_en;
    logic [DATA_WIDTH-1:0] value;
    logic [CNT_W-1:0]      pos;
    logic [CNT_W-1:0]      count;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/ioole_cell.sv
module ioole_cell (
  input  logic                             clk_i,
  input  logic [ioole_pkg::IDX_W-1:0]      cell_idx_i,
  input  ioole_pkg::cell_ctrl_t            ctrl_i,
  input  logic                             rem_en_i,
  input  logic [ioole_pkg::DATA_WIDTH-1:0] left_i,
  input  logic [ioole_pkg::DATA_WIDTH-1:0] right_i,
  input  logic                             hit_i,
  output logic                             hit_o,
  output logic                             first_o,
  output logic [ioole_pkg::DATA_WIDTH-1:0] slot_o,
  output logic [ioole_pkg::DATA_WIDTH-1:0] rd_o
);
  import ioole_pkg::*;

  logic [DATA_WIDTH-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]      idx;
  logic                  live;
  logic                  eq;

  // local compare against the broadcast value
  assign idx     = CNT_W'(cell_idx_i);
  assign live    = idx < ctrl_i.count;
  assign eq      = live && (slot_q == ctrl_i.value);
  assign hit_o   = hit_i | eq;
  assign first_o = eq & ~hit_i;
  assign slot_o  = slot_q;
  assign rd_o    = (idx == ctrl_i.pos) ? slot_q : '0;

  // shift right on insert, shift left from the first match on remove
  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.ins_en) begin
      if (idx == ctrl_i.pos) begin
        slot_d = ctrl_i.value;
      end else if (idx > ctrl_i.pos) begin
        slot_d = left_i;
      end
    end
    if (rem_en_i && hit_o) begin
      slot_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

>>> hw/rtl/indexed_ordered_list_engine_core.sv
// a request accepted while idle is latched with busy, executed, and its result registered and strobed on done_o
// a new request is not accepted while busy; busy is high for the single execute cycle
// the execute cycle compares all slot cells at once and ripples the first-match chain
// results are strobed for one cycle and cannot be stalled by the receiver
// reset clears the entry count and the handshake state; slot contents are not cleared
module indexed_ordered_list_engine_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ioole_pkg::req_t req_i,
  output logic            done_o,
  output ioole_pkg::res_t res_o
);
  import ioole_pkg::*;

  req_t             req_q;
  logic             busy_q;
  logic             done_q;
  res_t             res_q, res_d;
  logic [CNT_W-1:0] count_q, count_d;

  cell_ctrl_t            ctrl;
  logic                  rem_en;
  logic [CAPACITY:0]     hit_w;
  logic [CAPACITY-1:0]   first_w;
  logic [DATA_WIDTH-1:0] slot_w [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_w   [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_any;
  logic [IDX_W-1:0]      midx;
  logic                  pos_le_cnt;
  logic                  pos_lt_cnt;
  logic                  is_full;

  assign busy = busy_q;

  // request decode against the current count
  assign pos_le_cnt = {1'b0, req_q.position} <= {1'b0, count_q};
  assign pos_lt_cnt = {1'b0, req_q.position} < {1'b0, count_q};
  assign is_full    = count_q == CNT_W'(CAPACITY);

  assign ctrl.ins_en = busy_q && (req_q.req_type == REQ_INSERT) && pos_le_cnt && !is_full;
  assign ctrl.value  = req_q.value;
  assign ctrl.pos    = CNT_W'(req_q.position);
  assign ctrl.count  = count_q;
  assign rem_en      = busy_q && (req_q.req_type == REQ_REMOVE) && hit_w[CAPACITY];

  // row of slot cells with the first-match chain
  assign hit_w[0] = 1'b0;
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ioole_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .ctrl_i     (ctrl),
      .rem_en_i   (rem_en),
      .left_i     ((g == 0) ? slot_w[g] : slot_w[(g == 0) ? 0 : g - 1]),
      .right_i    ((g == CAPACITY - 1) ? slot_w[g] : slot_w[(g == CAPACITY - 1) ? g : g + 1]),
      .hit_i      (hit_w[g]),
      .hit_o      (hit_w[g+1]),
      .first_o    (first_w[g]),
      .slot_o     (slot_w[g]),
      .rd_o       (rd_w[g])
    );
  end

  // encode the one-hot first match and gather the addressed slot
  always_comb begin
    midx   = '0;
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_w[i]) begin
        midx = midx | IDX_W'(i);
      end
      rd_any = rd_any | rd_w[i];
    end
  end

  // result and next count
  always_comb begin
    count_d           = count_q;
    res_d             = '0;
    res_d.status      = ST_OK;
    unique case (req_q.req_type)
      REQ_INSERT: begin
        if (!pos_le_cnt) begin
          res_d.status = ST_RANGE;
        end else if (is_full) begin
          res_d.status = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (hit_w[CAPACITY]) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          res_d.status = ST_NOTFOUND;
        end
      end
      REQ_FIND: begin
        if (hit_w[CAPACITY]) begin
          res_d.match_found = 1'b1;
          res_d.match_index = 4'(midx);
        end else begin
          res_d.status = ST_NOTFOUND;
        end
      end
      REQ_RETRIEVE: begin
        if (pos_lt_cnt) begin
          res_d.read_data = 32'(rd_any);
        end else begin
          res_d.status = ST_RANGE;
        end
      end
      REQ_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    res_d.entry_count = 5'(count_d);
    res_d.is_empty    = count_d == '0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q <= start && !busy_q;
      done_q <= busy_q;
      if (busy_q) begin
        count_q <= count_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      req_q <= req_i;
    end
    if (busy_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // every execute cycle yields exactly one strobe in the next cycle
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("execute cycle not followed by result strobe");

  // a strobe only follows an execute cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without execute cycle");

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // empty flag tracks the reported count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.is_empty == (res_o.entry_count == 5'd0)))
    else $error("empty flag disagrees with entry count");

  // a match is only reported with an ok status
  a_match_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.match_found |-> res_o.status == ST_OK)
    else $error("match reported with error status");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ioole_pkg::*;

  localparam int LAST_REQ_CODE = 7;
  localparam int IDLE_PCT_A    = 38;
  localparam int IDLE_PCT_B    = 49;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_CYCLES  = 10;

  // random episode styles
  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIX    = 2;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  // list contents and count as the block should hold them
  logic [DATA_WIDTH-1:0] list_slots [CAPACITY];
  int                    list_count = 0;

  req_t pending_req_q [$];
  res_t expected_res_q [$];
  logic [31:0] value_pool [8];

  int total_items  = 0;
  int issued_cnt   = 0;
  int accepted_cnt = 0;
  int err_cnt      = 0;

  indexed_ordered_list_engine_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  // run limit
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // apply one request to the list and return its result beat
  function automatic res_t predict_list_op(req_t r);
    res_t o;
    int   m;
    int   i;
    o        = '0;
    o.status = ST_OK;
    case (r.req_type)
      REQ_INSERT: begin
        if (int'(r.position) > list_count) begin
          o.status = ST_RANGE;
        end else if (list_count >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          for (i = list_count; i > int'(r.position); i--) list_slots[i] = list_slots[i-1];
          list_slots[r.position] = r.value;
          list_count++;
        end
      end
      REQ_REMOVE, REQ_FIND: begin
        // scan from the top so the lowest match wins
        m = list_count;
        for (i = list_count - 1; i >= 0; i--) if (list_slots[i] == r.value) m = i;
        if (m >= list_count) begin
          o.status = ST_NOTFOUND;
        end else if (r.req_type == REQ_FIND) begin
          o.match_found = 1'b1;
          o.match_index = 4'(m);
        end else begin
          for (i = m; i + 1 < list_count; i++) list_slots[i] = list_slots[i+1];
          list_count--;
        end
      end
      REQ_RETRIEVE: begin
        if (int'(r.position) >= list_count) o.status = ST_RANGE;
        else o.read_data = list_slots[r.position];
      end
      REQ_CLEAR: begin
        list_count = 0;
      end
      default: ;
    endcase
    o.entry_count = 5'(list_count);
    o.is_empty    = (list_count == 0);
    return o;
  endfunction

  // mostly pool values so that finds and removes hit, sometimes anything
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic void push_req(req_type_e op, logic [31:0] val, logic [4:0] pos);
    req_t r;
    r.req_type = op;
    r.value    = val;
    r.position = pos;
    pending_req_q.push_back(r);
  endfunction

  // driver: present request beats at the falling edge, hold until taken
  always @(negedge clk_i) begin
    int idle_pct;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && accepted_cnt < issued_cnt)) begin
      if (issued_cnt < total_items / 3) idle_pct = IDLE_PCT_A;
      else if (issued_cnt < 2 * total_items / 3) idle_pct = IDLE_PCT_B;
      else idle_pct = 0;
      if (pending_req_q.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        req_i <= pending_req_q.pop_front();
        issued_cnt++;
      end
    end
  end

  // monitor: check result beats and predict accepted requests
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_res_q.size() == 0) begin
          if (err_cnt < MAX_REPORTS) $display("unexpected result beat: %p", res_o);
          err_cnt++;
        end else begin
          want = expected_res_q.pop_front();
          if (res_o.status !== want.status || res_o.match_found !== want.match_found ||
              res_o.match_index !== want.match_index || res_o.read_data !== want.read_data ||
              res_o.entry_count !== want.entry_count || res_o.is_empty !== want.is_empty) begin
            if (err_cnt < MAX_REPORTS) begin
              $display("mismatch exp st=%0d mf=%0d mi=%0d rd=%h cnt=%0d emp=%0d",
                       want.status, want.match_found, want.match_index, want.read_data,
                       want.entry_count, want.is_empty);
              $display("         got st=%0d mf=%0d mi=%0d rd=%h cnt=%0d emp=%0d",
                       res_o.status, res_o.match_found, res_o.match_index, res_o.read_data,
                       res_o.entry_count, res_o.is_empty);
            end
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        expected_res_q.push_back(predict_list_op(req_i));
        accepted_cnt++;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int         n;
    int         mode;
    int         len;
    int         k;
    int         roll;
    int         est;
    logic [4:0] pos;

    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h0000_0001;
    for (k = 4; k < 8; k++) value_pool[k] = $urandom;

    // empty list corners
    push_req(REQ_RETRIEVE, 32'h0, 5'd0);
    push_req(REQ_REMOVE, 32'hDEAD_BEEF, 5'd0);
    push_req(REQ_FIND, 32'h0, 5'd0);
    push_req(REQ_INSERT, 32'h1, 5'd1);
    // build: end, front, middle and a duplicate
    push_req(REQ_INSERT, 32'h0000_0000, 5'd0);
    push_req(REQ_INSERT, 32'hFFFF_FFFF, 5'd1);
    push_req(REQ_INSERT, 32'h1234_5678, 5'd0);
    push_req(REQ_INSERT, 32'hA5A5_A5A5, 5'd2);
    push_req(REQ_INSERT, 32'h0000_0000, 5'd4);
    push_req(REQ_FIND, 32'h0000_0000, 5'd0);
    push_req(REQ_FIND, 32'hFFFF_FFFF, 5'd0);
    push_req(REQ_FIND, 32'h5555_5555, 5'd0);
    push_req(REQ_RETRIEVE, 32'h0, 5'd4);
    push_req(REQ_RETRIEVE, 32'h0, 5'd5);
    push_req(REQ_RETRIEVE, 32'h0, 5'd31);
    push_req(REQ_INSERT, 32'h7777_7777, 5'd31);
    push_req(REQ_REMOVE, 32'h0000_0000, 5'd0);
    push_req(REQ_REMOVE, 32'h5555_5555, 5'd0);
    push_req(REQ_FIND, 32'h0000_0000, 5'd0);
    // unused request codes
    for (k = int'(REQ_CLEAR) + 1; k <= LAST_REQ_CODE; k++)
      push_req(req_type_e'(3'(k)), $urandom, 5'($urandom));
    push_req(REQ_CLEAR, 32'h0, 5'd0);
    push_req(REQ_CLEAR, 32'h0, 5'd0);
    push_req(REQ_RETRIEVE, 32'h0, 5'd0);

    // random episodes; est is a rough count used only to aim positions
    n   = 0;
    est = 0;
    while (n < RANDOM_ITEMS) begin
      mode = $urandom_range(MODE_GROW, MODE_MIX);
      len  = $urandom_range(20, 60);
      for (k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) pos = 5'($urandom);
        else pos = 5'($urandom_range(0, est));
        if (mode == MODE_SHRINK) roll = (roll < 60) ? 50 : (roll < 65 ? 99 : roll - 65);
        else if (mode == MODE_GROW) roll = (roll < 70) ? 0 : 30 + roll - 70;
        if (roll < 30) begin
          push_req(REQ_INSERT, pick_value(), pos);
          if (int'(pos) <= est && est < CAPACITY) est++;
        end else if (roll < 45) begin
          push_req(REQ_FIND, pick_value(), 5'($urandom));
        end else if (roll < 60) begin
          push_req(REQ_RETRIEVE, 32'($urandom), pos);
        end else if (roll < 88) begin
          push_req(REQ_REMOVE, pick_value(), 5'($urandom));
          if (est > 0) est--;
        end else if (roll < 95) begin
          push_req(REQ_CLEAR, 32'($urandom), 5'($urandom));
          est = 0;
        end else begin
          push_req(req_type_e'(3'($urandom_range(int'(REQ_CLEAR) + 1, LAST_REQ_CODE))),
                   $urandom, 5'($urandom));
        end
        n++;
      end
    end
    total_items = pending_req_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_req_q.size() == 0 && accepted_cnt == issued_cnt);
    wait (expected_res_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0 && expected_res_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
